// ----- rtl/vao_pkg.sv -----
// ----------------------------------------------------------------------------
// vao_pkg - shared types and codes of the voice allocator
// Command codes, internal operation codes, action codes and the words
// passed between the front queue, the allocation engine and the top level.
// ----------------------------------------------------------------------------
package vao_pkg;

	// command codes on the input port
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STOP  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// operations after classification in the front queue
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// action codes of a result word
	localparam logic [1:0] ACT_IGNORED = 2'd0;
	localparam logic [1:0] ACT_STARTED = 2'd1;
	localparam logic [1:0] ACT_STOPPED = 2'd2;
	localparam logic [1:0] ACT_CLEARED = 2'd3;

	// start time given to a voice freed by a stop
	localparam logic [31:0] TIME_NONE = 32'hFFFF_FFFF;

	// classified command word held in the front queue
	typedef struct packed {
		logic [1:0]  op;
		logic [23:0] word;
		logic [31:0] stamp;
	} cmd_word_t;

	// result word produced by the engine
	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  voice_index;
		logic [23:0] voice_word;
		logic [7:0]  enable_mask;
		logic        stolen;
	} res_word_t;

endpackage

// ----- rtl/vao_front.sv -----
// ----------------------------------------------------------------------------
// vao_front - command intake
// Accepts command words, classifies the command code and holds up to two
// words for the allocation engine.
// ----------------------------------------------------------------------------
module vao_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          cmd,
	input  logic [23:0]         note_word,
	input  logic [31:0]         time_stamp,
	output logic                head_valid,
	output vao_pkg::cmd_word_t  head,
	input  logic                head_pop
);

	vao_pkg::cmd_word_t entry_q [2];
	vao_pkg::cmd_word_t in_word;
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               do_push;
	logic               do_pop;

	// classify the incoming command
	always_comb begin
		in_word.word  = note_word;
		in_word.stamp = time_stamp;
		case (cmd)
			vao_pkg::CMD_START: in_word.op = vao_pkg::OP_START;
			vao_pkg::CMD_STOP:  in_word.op = vao_pkg::OP_STOP;
			vao_pkg::CMD_CLEAR: in_word.op = vao_pkg::OP_CLEAR;
			default:            in_word.op = vao_pkg::OP_NONE;
		endcase
	end

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = head_pop && head_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= in_word;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/vao_back.sv -----
// ----------------------------------------------------------------------------
// vao_back - voice allocation engine
// Holds the voice table, matches, allocates, frees and steals voices, and
// keeps one result word ready for the output side.
// ----------------------------------------------------------------------------
module vao_back #(
	parameter int NUM_VOICES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  vao_pkg::cmd_word_t  head,
	output logic                head_pop,
	output logic                res_valid,
	output vao_pkg::res_word_t  res,
	input  logic                res_pop
);

	localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_VOICES - 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic [NUM_VOICES-1:0] active_q;
	logic [23:0]           words_q [NUM_VOICES];
	logic [31:0]           times_q [NUM_VOICES];

	logic                  state_q;
	logic [IDX_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      best_q;
	logic [31:0]           best_time_q;
	logic                  res_valid_q;
	vao_pkg::res_word_t    res_q;

	logic [NUM_VOICES-1:0] match;
	logic                  match_any;
	logic [IDX_W-1:0]      match_idx;
	logic                  free_any;
	logic [IDX_W-1:0]      free_idx;
	logic                  cand_less;
	logic [IDX_W-1:0]      cand_idx;
	logic [31:0]           cand_time;
	logic                  slot_free;

	logic                  want;
	logic                  commit;
	logic                  go_scan;
	logic [1:0]            c_action;
	logic [IDX_W-1:0]      c_idx;
	logic [23:0]           c_word;
	logic                  c_stole;
	logic                  wr_en;
	logic                  wr_active;
	logic [23:0]           wr_word;
	logic [31:0]           wr_time;
	logic                  clr_all;
	logic [NUM_VOICES-1:0] mask_next;
	logic [31:0]           idx_ext;
	logic [31:0]           mask_ext;

	// parallel note match and free-voice search, lowest index wins
	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		free_any  = 1'b0;
		free_idx  = '0;
		for (int v = NUM_VOICES - 1; v >= 0; v--) begin
			match[v] = active_q[v] && (words_q[v] == head.word);
			if (match[v]) begin
				match_any = 1'b1;
				match_idx = IDX_W'(v);
			end
			if (!active_q[v]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(v);
			end
		end
	end

	// one step of the oldest-voice scan
	assign cand_less = (times_q[cnt_q] < best_time_q);
	assign cand_idx  = cand_less ? cnt_q : best_q;
	assign cand_time = cand_less ? times_q[cnt_q] : best_time_q;
	assign slot_free = !res_valid_q || res_pop;

	// command decision
	always_comb begin
		want      = 1'b0;
		go_scan   = 1'b0;
		c_action  = vao_pkg::ACT_IGNORED;
		c_idx     = '0;
		c_word    = '0;
		c_stole   = 1'b0;
		wr_en     = 1'b0;
		wr_active = 1'b0;
		wr_word   = '0;
		wr_time   = '0;
		clr_all   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					case (head.op)
						vao_pkg::OP_START: begin
							if (match_any) begin
								want = 1'b1;
							end else if (free_any || (NUM_VOICES == 1)) begin
								want      = 1'b1;
								c_action  = vao_pkg::ACT_STARTED;
								c_idx     = free_any ? free_idx : '0;
								c_word    = head.word;
								c_stole   = !free_any;
								wr_en     = 1'b1;
								wr_active = 1'b1;
								wr_word   = head.word;
								wr_time   = head.stamp;
							end else begin
								go_scan = 1'b1;
							end
						end
						vao_pkg::OP_STOP: begin
							want = 1'b1;
							if (match_any) begin
								c_action = vao_pkg::ACT_STOPPED;
								c_idx    = match_idx;
								wr_en    = 1'b1;
								wr_time  = vao_pkg::TIME_NONE;
							end
						end
						vao_pkg::OP_CLEAR: begin
							want     = 1'b1;
							c_action = vao_pkg::ACT_CLEARED;
							clr_all  = 1'b1;
						end
						default: begin
							want = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (cnt_q == LAST) begin
					want      = 1'b1;
					c_action  = vao_pkg::ACT_STARTED;
					c_idx     = cand_idx;
					c_word    = head.word;
					c_stole   = 1'b1;
					wr_en     = 1'b1;
					wr_active = 1'b1;
					wr_word   = head.word;
					wr_time   = head.stamp;
				end
			end
			default: begin
				want = 1'b0;
			end
		endcase
		commit = want && slot_free;
	end

	assign head_pop = commit;

	// enable mask after this command
	always_comb begin
		mask_next = active_q;
		if (clr_all) begin
			mask_next = '0;
		end else if (wr_en) begin
			mask_next[c_idx] = wr_active;
		end
	end

	assign idx_ext  = 32'(c_idx);
	assign mask_ext = 32'(mask_next);

	// voice table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			for (int v = 0; v < NUM_VOICES; v++) begin
				words_q[v] <= '0;
				times_q[v] <= '0;
			end
		end else if (commit) begin
			if (clr_all) begin
				active_q <= '0;
				for (int v = 0; v < NUM_VOICES; v++) begin
					words_q[v] <= '0;
					times_q[v] <= '0;
				end
			end else if (wr_en) begin
				active_q[c_idx] <= wr_active;
				words_q[c_idx]  <= wr_word;
				times_q[c_idx]  <= wr_time;
			end
		end
	end

	// sequencer and scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			best_q      <= '0;
			best_time_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (go_scan) begin
						state_q     <= ST_SCAN;
						cnt_q       <= IDX_W'(1);
						best_q      <= '0;
						best_time_q <= times_q[0];
					end
				end
				ST_SCAN: begin
					if (cnt_q != LAST) begin
						cnt_q       <= cnt_q + IDX_W'(1);
						best_q      <= cand_idx;
						best_time_q <= cand_time;
					end else if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result slot valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit) begin
			res_valid_q <= 1'b1;
		end else if (res_pop) begin
			res_valid_q <= 1'b0;
		end
	end

	// result slot payload
	always_ff @(posedge clk) begin
		if (commit) begin
			res_q.action      <= c_action;
			res_q.voice_index <= idx_ext[2:0];
			res_q.voice_word  <= c_word;
			res_q.enable_mask <= mask_ext[7:0];
			res_q.stolen      <= c_stole;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- rtl/voice_allocator_oldest_steal.sv -----
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal - polyphonic voice allocator, oldest stealing
// Results: a result word is registered and is visible in the cycle after its command
// is accepted by the engine; a steal first scans the voice start times for the oldest.
// Throughput: one command per cycle while no steal is needed and the result slot
// is free or being popped; a steal holds the engine while it scans.
// Reset: arst_n clears the queues and all voices (inactive, word and time 0).
// ----------------------------------------------------------------------------
module voice_allocator_oldest_steal #(
	parameter int NUM_VOICES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [23:0] note_word,
	input  logic [31:0] time_stamp,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  action,
	output logic [2:0]  voice_index,
	output logic [23:0] voice_word,
	output logic [7:0]  enable_mask,
	output logic        stolen
);

	vao_pkg::cmd_word_t head;
	vao_pkg::res_word_t res;
	logic               head_valid;
	logic               head_pop;
	logic               res_valid;

	// command intake and queue
	vao_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.note_word  (note_word),
		.time_stamp (time_stamp),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop)
	);

	// allocation engine with result slot
	vao_back #(
		.NUM_VOICES (NUM_VOICES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.res_valid  (res_valid),
		.res        (res),
		.res_pop    (pop)
	);

	assign empty       = !res_valid;
	assign action      = res.action;
	assign voice_index = res.voice_index;
	assign voice_word  = res.voice_word;
	assign enable_mask = res.enable_mask;
	assign stolen      = res.stolen;

endmodule

// ----- tb/sv/voice_allocator_oldest_steal_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal_tb - self-checking bench of the voice allocator
// Directed note commands first (duplicate starts, stealing with ties, stops
// with and without a match, clear, the unused command), then random
// commands over a small pool of note words so that voices fill and get
// stolen. A scoreboard keeps its own copy of the voices, predicts each
// result word and compares it field by field as it is popped.
// ----------------------------------------------------------------------------
module voice_allocator_oldest_steal_tb;

	localparam int NUM_VOICES   = 8;
	localparam int RANDOM_WORDS = 2000;
	localparam int POOL_SIZE    = 12;

	// command code with no meaning to the block
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// voice model and store of predicted result words
	class voice_tracker;
		bit                 active[NUM_VOICES];
		logic [23:0]        words[NUM_VOICES];
		logic [31:0]        starts[NUM_VOICES];
		vao_pkg::res_word_t expected_words[$];
		int                 mismatches;
		int                 accepted;

		function new();
			clear_voices();
			mismatches = 0;
			accepted   = 0;
		endfunction

		function void clear_voices();
			int v;
			for (v = 0; v < NUM_VOICES; v++) begin
				active[v] = 1'b0;
				words[v]  = '0;
				starts[v] = '0;
			end
		endfunction

		function int voice_playing(logic [23:0] w);
			int v;
			for (v = 0; v < NUM_VOICES; v++)
				if (active[v] && words[v] == w)
					return v;
			return -1;
		endfunction

		// work out the result word of one command and update the voices
		function vao_pkg::res_word_t allocate(logic [1:0] c, logic [23:0] w,
				logic [31:0] s);
			vao_pkg::res_word_t r;
			int                 hit;
			int                 pick;
			int                 v;
			r        = '0;
			r.action = vao_pkg::ACT_IGNORED;
			hit      = voice_playing(w);
			case (c)
				vao_pkg::CMD_START: begin
					if (hit < 0) begin
						pick = -1;
						for (v = 0; v < NUM_VOICES; v++)
							if (!active[v] && pick < 0)
								pick = v;
						// no free voice: steal the oldest, lowest index on a tie
						if (pick < 0) begin
							pick = 0;
							for (v = 1; v < NUM_VOICES; v++)
								if (starts[v] < starts[pick])
									pick = v;
							r.stolen = 1'b1;
						end
						active[pick]  = 1'b1;
						words[pick]   = w;
						starts[pick]  = s;
						r.action      = vao_pkg::ACT_STARTED;
						r.voice_index = 3'(pick);
						r.voice_word  = w;
					end
				end
				vao_pkg::CMD_STOP: begin
					if (hit >= 0) begin
						active[hit]   = 1'b0;
						words[hit]    = '0;
						starts[hit]   = vao_pkg::TIME_NONE;
						r.action      = vao_pkg::ACT_STOPPED;
						r.voice_index = 3'(hit);
					end
				end
				vao_pkg::CMD_CLEAR: begin
					clear_voices();
					r.action = vao_pkg::ACT_CLEARED;
				end
				default: ;
			endcase
			for (v = 0; v < NUM_VOICES && v < 8; v++)
				r.enable_mask[v] = active[v];
			return r;
		endfunction

		function void note_command(logic [1:0] c, logic [23:0] w, logic [31:0] s);
			expected_words.push_back(allocate(c, w, s));
			accepted++;
		endfunction

		function void check_word(vao_pkg::res_word_t got);
			vao_pkg::res_word_t exp;
			if (expected_words.size() == 0) begin
				$error("result word popped with none expected");
				mismatches++;
				return;
			end
			exp = expected_words.pop_front();
			if (got.action !== exp.action) begin
				$error("action: expected %0d, got %0d", exp.action, got.action);
				mismatches++;
			end
			if (got.voice_index !== exp.voice_index) begin
				$error("voice_index: expected %0d, got %0d", exp.voice_index, got.voice_index);
				mismatches++;
			end
			if (got.voice_word !== exp.voice_word) begin
				$error("voice_word: expected %h, got %h", exp.voice_word, got.voice_word);
				mismatches++;
			end
			if (got.enable_mask !== exp.enable_mask) begin
				$error("enable_mask: expected %b, got %b", exp.enable_mask, got.enable_mask);
				mismatches++;
			end
			if (got.stolen !== exp.stolen) begin
				$error("stolen: expected %0d, got %0d", exp.stolen, got.stolen);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        push        = 1'b0;
	logic [1:0]  cmd         = vao_pkg::CMD_START;
	logic [23:0] note_word   = '0;
	logic [31:0] time_stamp  = '0;
	logic        pop         = 1'b0;
	logic        full;
	logic        empty;
	logic [1:0]  action;
	logic [2:0]  voice_index;
	logic [23:0] voice_word;
	logic [7:0]  enable_mask;
	logic        stolen;

	// burst phases: neither side idles
	bit           no_idle = 1'b0;
	voice_tracker tracker;

	voice_allocator_oldest_steal #(
		.NUM_VOICES(NUM_VOICES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.note_word  (note_word),
		.time_stamp (time_stamp),
		.empty      (empty),
		.pop        (pop),
		.action     (action),
		.voice_index(voice_index),
		.voice_word (voice_word),
		.enable_mask(enable_mask),
		.stolen     (stolen)
	);

	always #1 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int idle_length();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// offer one command word and hold it until the block takes it
	task automatic send_command(logic [1:0] c, logic [23:0] w, logic [31:0] s);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push       <= 1'b1;
		cmd        <= c;
		note_word  <= w;
		time_stamp <= s;
		do
			@(posedge clk);
		while (full);
		tracker.note_command(c, w, s);
	endtask

	// result side: check each popped word, stall at random
	initial begin : receiver
		vao_pkg::res_word_t got;
		int                 stall_left;
		bit                 hold_done;
		stall_left = 0;
		hold_done  = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.action      = action;
				got.voice_index = voice_index;
				got.voice_word  = voice_word;
				got.enable_mask = enable_mask;
				got.stolen      = stolen;
				tracker.check_word(got);
			end
			// one long hold-off so the input queue fills and stalls the sender
			if (!hold_done && tracker.accepted >= 500) begin
				hold_done  = 1'b1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop        <= 1'b1;
				stall_left = idle_length();
			end
		end
	end

	// stimulus
	initial begin : main
		logic [23:0] word_pool[POOL_SIZE];
		logic [31:0] time_count;
		logic [1:0]  c;
		logic [23:0] w;
		logic [31:0] s;
		int          r;
		int          i;
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unused command, stop with nothing playing, duplicate start
		send_command(CMD_UNUSED, 24'hFF_FFFF, 32'hFFFF_FFFF);
		send_command(vao_pkg::CMD_STOP, 24'h00_0000, 32'h0);
		send_command(vao_pkg::CMD_START, 24'h00_0000, 32'd5);
		send_command(vao_pkg::CMD_START, 24'h00_0000, 32'd99);
		send_command(vao_pkg::CMD_START, 24'hFF_FFFF, 32'hFFFF_FFFF);
		// fill the rest; voice 3 ties voice 0 on the oldest start time
		send_command(vao_pkg::CMD_START, 24'h00_0001, 32'd7);
		send_command(vao_pkg::CMD_START, 24'h80_0000, 32'd5);
		send_command(vao_pkg::CMD_START, 24'h55_5555, 32'd9);
		send_command(vao_pkg::CMD_START, 24'hAA_AAAA, 32'd12);
		send_command(vao_pkg::CMD_START, 24'h12_3456, 32'd20);
		send_command(vao_pkg::CMD_START, 24'h00_FF00, 32'd30);
		// steals: voice 0 wins the tie, then 3, then 2
		send_command(vao_pkg::CMD_START, 24'h0F_0F0F, 32'd40);
		send_command(vao_pkg::CMD_START, 24'hF0_F0F0, 32'd41);
		send_command(vao_pkg::CMD_START, 24'h3C_3C3C, 32'd0);
		send_command(vao_pkg::CMD_START, 24'h80_0000, 32'd50);
		// stop frees a voice, the next start takes it
		send_command(vao_pkg::CMD_STOP, 24'hFF_FFFF, 32'd0);
		send_command(vao_pkg::CMD_START, 24'h11_1111, 32'd0);
		send_command(vao_pkg::CMD_STOP, 24'hAB_CDEF, 32'd0);
		send_command(vao_pkg::CMD_STOP, 24'h00_0000, 32'd0);
		// all active again, steal the voice stamped zero
		send_command(vao_pkg::CMD_START, 24'h22_2222, 32'hFFFF_FFFF);
		send_command(vao_pkg::CMD_CLEAR, 24'hFF_FFFF, 32'hFFFF_FFFF);
		send_command(vao_pkg::CMD_STOP, 24'h11_1111, 32'd0);
		send_command(vao_pkg::CMD_START, 24'hFF_FFFF, 32'd0);
		send_command(CMD_UNUSED, 24'h00_0000, 32'd0);

		// random: a small pool of words keeps starts, stops and steals meeting
		for (i = 0; i < POOL_SIZE; i++)
			word_pool[i] = 24'($urandom);
		time_count = $urandom;
		for (i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 150 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 19) == 0)
				word_pool[$urandom_range(0, POOL_SIZE - 1)] = 24'($urandom);
			r = $urandom_range(0, 99);
			if (r < 58)
				c = vao_pkg::CMD_START;
			else if (r < 97)
				c = vao_pkg::CMD_STOP;
			else if (r < 98)
				c = vao_pkg::CMD_CLEAR;
			else
				c = CMD_UNUSED;
			if ($urandom_range(0, 9) == 0)
				w = 24'($urandom);
			else
				w = word_pool[$urandom_range(0, POOL_SIZE - 1)];
			r = $urandom_range(0, 99);
			if (r < 80) begin
				time_count = time_count + 32'($urandom_range(0, 3));
				s = time_count;
			end else if (r < 90)
				s = $urandom;
			else if (r < 95)
				s = '0;
			else
				s = 32'hFFFF_FFFF;
			send_command(c, w, s);
		end
		push    <= 1'b0;
		no_idle = 1'b0;

		// drain, then allow for a steal still in flight
		while (tracker.pending() > 0)
			@(posedge clk);
		repeat (2 * NUM_VOICES + 8) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
